### design/tksum_pkg.sv
`default_nettype none

package tksum_pkg;

	// Fixed field widths of the item and result.
	localparam int unsigned VAL_W  = 32;
	localparam int unsigned SUM_W  = 42;
	localparam int unsigned TOP_W  = 11;
	localparam int unsigned STAT_W = 2;

	// Largest K that the sum may cover.
	localparam logic [TOP_W-1:0] TOP_MAX = TOP_W'(1024);

	// Operation codes.
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// Status codes.
	localparam logic [STAT_W-1:0] STAT_DONE   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd2;

	typedef logic [VAL_W-1:0] val_t;

	// Shift command broadcast to every cell of the row.
	typedef struct packed {
		logic ins;
		logic rem;
	} ctl_t;

	// What each cell contributes to the reduction tree.
	typedef struct packed {
		logic hit;
		val_t kval;
		val_t k1val;
	} leaf_t;

	localparam int unsigned LEAF_W = $bits(leaf_t);

endpackage

`default_nettype wire

### design/top_k_sum_store.sv
`default_nettype none

// Sorted multiset store with a running sum of its K largest values. Values
// live in a row of CAPACITY cells kept in descending order; an insert opens
// a gap at the first smaller value and a remove closes the gap at the first
// match, every cell moving in the same cycle. Each item returns the sum of
// the K largest held values, a status (done, insert dropped because full, or
// remove of an absent value) and the number of values held. Items are
// handled one at a time, the next accepted only after the last is applied:
// the cells report a match flag and the values at sorted positions K-1 and
// K into a registered OR tree of clog2(CAPACITY) levels, then the apply
// state shifts the row and updates the sum, holding while a pending result
// is stalled. A new item is taken while the previous result still waits in the
// output register. K is written through the configuration channel, which is
// always ready; a write while the store holds values is ignored, zero reads
// as one and values above 1024 read as 1024.
module top_k_sum_store #(
	parameter int unsigned CAPACITY = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                op,
	input  tksum_pkg::val_t                     value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [tksum_pkg::SUM_W-1:0]         top_sum,
	output logic [tksum_pkg::STAT_W-1:0]        status,
	output logic [tksum_pkg::TOP_W-1:0]         held_count,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tksum_pkg::TOP_W-1:0]         top_count
);
	import tksum_pkg::*;

	// Count width, and the width in which counts, positions and K are compared.
	localparam int unsigned CW   = $clog2(CAPACITY + 1);
	localparam int unsigned CMPW = (CW > TOP_W) ? CW : TOP_W;
	localparam int unsigned LV   = $clog2(CAPACITY);
	localparam int unsigned WW   = $clog2(LV + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WAIT,
		S_APPLY
	} state_t;

	state_t              state_q;
	logic [WW-1:0]       wait_q;
	logic                op_q;
	val_t                v_q;
	logic [CW-1:0]       count_q;
	logic [SUM_W-1:0]    sum_q;
	logic [TOP_W-1:0]    k_q;
	logic                out_valid_q;
	logic [SUM_W-1:0]    out_sum_q;
	logic [STAT_W-1:0]   out_status_q;
	logic [TOP_W-1:0]    out_count_q;

	// Cell row wiring.
	val_t                cell_val  [CAPACITY];
	logic                cell_ge   [CAPACITY];
	leaf_t               cell_leaf [CAPACITY];
	logic [LEAF_W-1:0]   leaf_bits [CAPACITY];
	logic [LEAF_W-1:0]   root_bits;
	leaf_t               root_leaf;
	ctl_t                ctl;

	logic [CMPW-1:0]     count_x;
	logic [CMPW-1:0]     k_x;
	logic [CMPW-1:0]     next_count_x;
	logic                full;
	logic                apply_go;
	logic                do_ins;
	logic                do_rem;
	logic [SUM_W-1:0]    next_sum;
	logic [CW-1:0]       next_count;
	logic [STAT_W-1:0]   next_status;
	logic [TOP_W-1:0]    k_sat;

	assign count_x = CMPW'(count_q);
	assign k_x     = CMPW'(k_q);
	assign full    = count_q == CW'(CAPACITY);

	// The row only moves in the cycle the result is committed, and only when
	// the output register can take that result.
	assign apply_go = (state_q == S_APPLY) && (!out_valid_q || !out_stall);
	assign do_ins   = apply_go && (op_q == OP_INSERT) && !full;
	assign do_rem   = apply_go && (op_q == OP_REMOVE) && root_leaf.hit;
	assign ctl.ins  = do_ins;
	assign ctl.rem  = do_rem;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		val_t lval;
		logic lge;
		val_t rval;

		if (i == 0) begin : g_first
			assign lval = '0;
			assign lge  = 1'b1;
		end else begin : g_mid
			assign lval = cell_val[i-1];
			assign lge  = cell_ge[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign rval = '0;
		end else begin : g_body
			assign rval = cell_val[i+1];
		end

		tksum_cell #(
			.IDX  (i),
			.CMPW (CMPW)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.item_val  (v_q),
			.count     (count_x),
			.k         (k_x),
			.left_val  (lval),
			.left_ge   (lge),
			.right_val (rval),
			.val       (cell_val[i]),
			.ge        (cell_ge[i]),
			.leaf      (cell_leaf[i])
		);

		assign leaf_bits[i] = cell_leaf[i];
	end

	// Match flag and boundary values gathered over LV registered levels.
	tksum_tree #(
		.N (CAPACITY),
		.W (LEAF_W)
	) u_tree (
		.clk  (clk),
		.leaf (leaf_bits),
		.root (root_bits)
	);

	assign root_leaf = root_bits;

	// Sum update from the values crossing the boundary at sorted position K.
	// On insert the value at K-1 drops out when the new one lands above it; on
	// remove the value at K moves in when the removed one sat inside the top K.
	always_comb begin
		next_sum    = sum_q;
		next_count  = count_q;
		next_status = STAT_DONE;
		if (op_q == OP_INSERT) begin
			if (full) begin
				next_status = STAT_FULL;
			end else begin
				next_count = count_q + CW'(1);
				if (count_x < k_x) begin
					next_sum = sum_q + SUM_W'(v_q);
				end else if (root_leaf.kval < v_q) begin
					next_sum = sum_q + SUM_W'(v_q) - SUM_W'(root_leaf.kval);
				end
			end
		end else begin
			if (!root_leaf.hit) begin
				next_status = STAT_ABSENT;
			end else begin
				next_count = count_q - CW'(1);
				if (count_x <= k_x) begin
					next_sum = sum_q - SUM_W'(v_q);
				end else if (root_leaf.kval <= v_q) begin
					next_sum = sum_q - SUM_W'(v_q) + SUM_W'(root_leaf.k1val);
				end
			end
		end
	end

	assign next_count_x = CMPW'(next_count);

	// K saturates into the range one to 1024.
	always_comb begin
		k_sat = top_count;
		if (top_count == '0) begin
			k_sat = TOP_W'(1);
		end else if (top_count > TOP_MAX) begin
			k_sat = TOP_MAX;
		end
	end

	// Item payload is captured at acceptance and held until the next one.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_q <= op;
			v_q  <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			wait_q       <= '0;
			count_q      <= '0;
			sum_q        <= '0;
			k_q          <= TOP_W'(1);
			out_valid_q  <= 1'b0;
			out_sum_q    <= '0;
			out_status_q <= STAT_DONE;
			out_count_q  <= '0;
		end else begin
			// A result leaving in the same cycle as a new one is committed
			// is simply replaced, so valid stays high.
			if (out_valid_q && !out_stall && !apply_go) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && (count_q == '0)) begin
				k_q <= k_sat;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_WAIT;
						wait_q  <= WW'(LV);
					end
				end
				S_WAIT: begin
					if (wait_q == WW'(1)) begin
						state_q <= S_APPLY;
					end else begin
						wait_q <= wait_q - WW'(1);
					end
				end
				S_APPLY: begin
					if (apply_go) begin
						state_q      <= S_IDLE;
						count_q      <= next_count;
						sum_q        <= next_sum;
						out_valid_q  <= 1'b1;
						out_sum_q    <= next_sum;
						out_status_q <= next_status;
						out_count_q  <= next_count_x[TOP_W-1:0];
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall   = state_q != S_IDLE;
	assign out_valid  = out_valid_q;
	assign top_sum    = out_sum_q;
	assign status     = out_status_q;
	assign held_count = out_count_q;
	assign cfg_ready  = 1'b1;

endmodule

`default_nettype wire

### design/tksum_cell.sv
`default_nettype none

module tksum_cell #(
	parameter int unsigned IDX  = 0,
	parameter int unsigned CMPW = 11
) (
	input  logic                  clk,
	input  tksum_pkg::ctl_t       ctl,
	input  tksum_pkg::val_t       item_val,
	input  logic [CMPW-1:0]       count,
	input  logic [CMPW-1:0]       k,
	input  tksum_pkg::val_t       left_val,
	input  logic                  left_ge,
	input  tksum_pkg::val_t       right_val,
	output tksum_pkg::val_t       val,
	output logic                  ge,
	output tksum_pkg::leaf_t      leaf
);
	import tksum_pkg::*;

	localparam logic [CMPW-1:0] MY_IDX  = CMPW'(IDX);
	localparam logic [CMPW-1:0] MY_NEXT = CMPW'(IDX + 1);

	val_t val_q;
	logic vld;
	logic gt;

	// A cell holds a value when its position lies below the fill count.
	assign vld = MY_IDX < count;
	assign ge  = vld && (val_q >= item_val);
	assign gt  = vld && (val_q > item_val);
	assign val = val_q;

	assign leaf.hit   = vld && (val_q == item_val);
	assign leaf.kval  = (MY_NEXT == k) ? val_q : '0;
	assign leaf.k1val = (MY_IDX == k) ? val_q : '0;

	// Insert: the first cell below the new value takes it, later cells take
	// their left neighbor. Remove: from the first match on, take the right one.
	always_ff @(posedge clk) begin
		if (ctl.ins && !ge) begin
			val_q <= left_ge ? item_val : left_val;
		end else if (ctl.rem && !gt) begin
			val_q <= right_val;
		end
	end

endmodule

`default_nettype wire

### design/tksum_tree.sv
`default_nettype none

module tksum_tree #(
	parameter int unsigned N = 1024,
	parameter int unsigned W = 65
) (
	input  logic         clk,
	input  logic [W-1:0] leaf [N],
	output logic [W-1:0] root
);
	localparam int unsigned LV = $clog2(N);
	localparam int unsigned P  = 1 << LV;

	logic [W-1:0] lf     [P];
	logic [W-1:0] node_q [1:P-1];

	// Pad to a power of two with zero leaves.
	for (genvar j = 0; j < P; j++) begin : g_pad
		if (j < N) begin : g_real
			assign lf[j] = leaf[j];
		end else begin : g_zero
			assign lf[j] = '0;
		end
	end

	// Heap layout: node j has children 2j and 2j+1, one register per level.
	for (genvar j = 1; j < P; j++) begin : g_node
		if (2 * j >= P) begin : g_bottom
			always_ff @(posedge clk) begin
				node_q[j] <= lf[2*j-P] | lf[2*j+1-P];
			end
		end else begin : g_inner
			always_ff @(posedge clk) begin
				node_q[j] <= node_q[2*j] | node_q[2*j+1];
			end
		end
	end

	assign root = node_q[1];

endmodule

`default_nettype wire

### design/tksum_chk.sv
`default_nettype none

module tksum_chk #(
	parameter int unsigned CAPACITY = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [tksum_pkg::SUM_W-1:0]         top_sum,
	input  logic [tksum_pkg::STAT_W-1:0]        status,
	input  logic [tksum_pkg::TOP_W-1:0]         held_count
);
	import tksum_pkg::*;

	localparam logic [TOP_W-1:0] CAP_CNT = TOP_W'(CAPACITY);

	// One item at a time: the input side closes right after an acceptance.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in flight");

	// A dropped insert can only come from a full store.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_FULL) |-> held_count == CAP_CNT)
		else $error("full status with a store that is not full");

	// An empty store sums to zero.
	a_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(CAPACITY < 2048) && out_valid && (held_count == '0) |-> top_sum == '0)
		else $error("nonzero sum with an empty store");

	// Only the three defined status codes appear.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STAT_DONE) || (status == STAT_FULL) ||
			(status == STAT_ABSENT))
		else $error("undefined status code");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(top_sum) &&
			$stable(status) && $stable(held_count))
		else $error("stalled result changed");

endmodule

bind top_k_sum_store tksum_chk #(
	.CAPACITY (CAPACITY)
) u_tksum_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.top_sum    (top_sum),
	.status     (status),
	.held_count (held_count)
);

`default_nettype wire

### tb/tksum_checker.sv
`timescale 1ns / 100ps

module tksum_checker #(
	parameter int unsigned DEPTH = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic                         op,
	input  tksum_pkg::val_t              value,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [tksum_pkg::SUM_W-1:0]  top_sum,
	input  logic [tksum_pkg::STAT_W-1:0] status,
	input  logic [tksum_pkg::TOP_W-1:0]  held_count,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [tksum_pkg::TOP_W-1:0]  top_count,
	output int                           pending,
	output int                           fail_count
);
	import tksum_pkg::*;

	typedef struct packed {
		logic [SUM_W-1:0]  sum;
		logic [STAT_W-1:0] stat;
		logic [TOP_W-1:0]  count;
	} store_result_t;

	// Shadow copy of the store, kept in descending order.
	val_t          sorted_q[$];
	int unsigned   k_limit;
	store_result_t expected_q[$];

	function automatic logic [SUM_W-1:0] largest_k_sum();
		logic [SUM_W-1:0] acc;
		int lim;
		acc = '0;
		lim = (sorted_q.size() < k_limit) ? sorted_q.size() : k_limit;
		for (int i = 0; i < lim; i++) begin
			acc += SUM_W'(sorted_q[i]);
		end
		return acc;
	endfunction

	// A new K only takes effect while the store is empty; out-of-range values clamp.
	function automatic void set_top_count(input logic [TOP_W-1:0] k);
		if (sorted_q.size() == 0) begin
			if (k == '0) begin
				k_limit = 1;
			end else if (k > TOP_MAX) begin
				k_limit = TOP_MAX;
			end else begin
				k_limit = k;
			end
		end
	endfunction

	// Applies one item to the shadow store and returns the result it must produce.
	function automatic store_result_t apply_item(input logic o, input val_t v);
		store_result_t r;
		int pos;
		r.stat = STAT_DONE;
		pos = 0;
		if (o == OP_INSERT) begin
			if (sorted_q.size() >= DEPTH) begin
				r.stat = STAT_FULL;
			end else begin
				while (pos < sorted_q.size() && sorted_q[pos] >= v) pos++;
				sorted_q.insert(pos, v);
			end
		end else begin
			while (pos < sorted_q.size() && sorted_q[pos] != v) pos++;
			if (pos >= sorted_q.size()) begin
				r.stat = STAT_ABSENT;
			end else begin
				sorted_q.delete(pos);
			end
		end
		r.sum = largest_k_sum();
		r.count = TOP_W'(sorted_q.size());
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		store_result_t want;
		if (!arst_n) begin
			sorted_q.delete();
			expected_q.delete();
			k_limit = 1;
			pending = 0;
			fail_count = 0;
		end else begin
			// The result leaving now always belongs to an earlier item.
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result: top_sum %0d status %0d held_count %0d",
						top_sum, status, held_count);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (top_sum !== want.sum) begin
						$error("top_sum mismatch: expected %0d, actual %0d", want.sum, top_sum);
						fail_count++;
					end
					if (status !== want.stat) begin
						$error("status mismatch: expected %0d, actual %0d", want.stat, status);
						fail_count++;
					end
					if (held_count !== want.count) begin
						$error("held_count mismatch: expected %0d, actual %0d",
							want.count, held_count);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				set_top_count(top_count);
			end
			if (in_valid && !in_stall) begin
				expected_q.push_back(apply_item(op, value));
			end
			pending = expected_q.size();
		end
	end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the top-K sum store. A checker module sits beside
// the block, mirrors every accepted item in a sorted shadow store and compares
// each result with its prediction. This module only produces traffic:
// a short directed sequence, then random phases under several values of K,
// ending with a phase that fills the store to capacity.
module tb;
	import tksum_pkg::*;

	localparam int unsigned STORE_DEPTH = 1024;
	// The settle wait gives anything still inside the row time to come out.
	localparam int unsigned SETTLE_CYCLES = 20;
	// The receiver's long hold-off is the longest legal stretch with no
	// handshake at all; the watchdog allows more than ten times that.
	localparam int unsigned LONG_HOLD = 400;
	localparam int unsigned QUIET_LIMIT = 5000;

	typedef enum int {
		RX_FREE,
		RX_COIN,
		RX_LIGHT,
		RX_BLOCKED
	} rx_mode_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              op;
	val_t              value;
	logic              out_valid;
	logic              out_stall;
	logic [SUM_W-1:0]  top_sum;
	logic [STAT_W-1:0] status;
	logic [TOP_W-1:0]  held_count;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [TOP_W-1:0]  cfg_top_count;
	int                pending;
	int                fail_count;

	// Values believed to be in the store; used only to aim removes at real
	// entries and to empty the store between phases.
	val_t live_vals[$];
	// A small set of values per phase makes duplicates and hits common.
	val_t value_pool[6];
	int   burst_left;
	bit   hold_request;
	int   quiet_cycles;

	top_k_sum_store #(
		.CAPACITY(STORE_DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.top_sum   (top_sum),
		.status    (status),
		.held_count(held_count),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.top_count (cfg_top_count)
	);

	tksum_checker #(
		.DEPTH(STORE_DEPTH)
	) u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.top_sum   (top_sum),
		.status    (status),
		.held_count(held_count),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.top_count (cfg_top_count),
		.pending   (pending),
		.fail_count(fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Draws a value: mostly from the phase's pool, otherwise fully random,
	// an extreme, a small number or one just below the top of the range.
	function automatic val_t pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return value_pool[$urandom_range(0, 5)];
		if (r < 60) return val_t'($urandom);
		if (r < 65) return '0;
		if (r < 70) return {VAL_W{1'b1}};
		if (r < 85) return val_t'($urandom_range(0, 15));
		return {24'hFFFFFF, 8'($urandom)};
	endfunction

	task automatic refill_pool();
		foreach (value_pool[i]) begin
			value_pool[i] = val_t'($urandom) >> $urandom_range(0, 31);
		end
	endtask

	// Drops valid for a random gap between bursts; most gaps are short, some
	// are long enough to let the row drain completely.
	task automatic take_gap();
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (gap - 1) @(negedge clk);
	endtask

	// Offers one item and holds it until accepted. Within a burst valid stays
	// high from one item to the next.
	task automatic issue(input logic o, input val_t v);
		int idx;
		if (burst_left == 0) begin
			take_gap();
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		op <= o;
		value <= v;
		do @(posedge clk); while (in_stall);
		if (o == OP_INSERT) begin
			if (live_vals.size() < STORE_DEPTH) live_vals.push_back(v);
		end else begin
			for (idx = 0; idx < live_vals.size(); idx++) begin
				if (live_vals[idx] == v) break;
			end
			if (idx < live_vals.size()) live_vals.delete(idx);
		end
	endtask

	// Stops offering items and waits until every result is back and the row
	// has settled. Configuration writes happen only after this.
	task automatic quiesce();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_top_count(input logic [TOP_W-1:0] k);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_top_count <= k;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain_store();
		while (live_vals.size() != 0) begin
			issue(OP_REMOVE, live_vals[$urandom_range(0, live_vals.size() - 1)]);
		end
	endtask

	// Mostly well-formed traffic: inserts, removes of values that are held,
	// and a share of removes that usually miss.
	task automatic random_phase(input int count);
		int pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (live_vals.size() != 0 && pick < 35) begin
				issue(OP_REMOVE, live_vals[$urandom_range(0, live_vals.size() - 1)]);
			end else if (pick < 45) begin
				issue(OP_REMOVE, pick_value());
			end else begin
				issue(OP_INSERT, pick_value());
			end
		end
	endtask

	// The receiver runs on its own: stretches of free flow, coin-flip stalls,
	// occasional stalls and solid blocks. When the stimulus asks for it, it
	// holds off for a long stretch so the block fills and stalls its input.
	initial begin
		int span;
		rx_mode_t mode;
		out_stall = 1'b0;
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				repeat (LONG_HOLD) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
			end else begin
				mode = rx_mode_t'($urandom_range(0, 3));
				span = $urandom_range(8, 60);
				repeat (span) begin
					@(negedge clk);
					case (mode)
						RX_FREE: out_stall <= 1'b0;
						RX_COIN: out_stall <= 1'($urandom_range(0, 1));
						RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
						default: out_stall <= 1'b1;
					endcase
				end
			end
		end
	end

	// Watchdog: any handshake restarts the count, so only a real hang ends
	// the run here.
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("top_k_sum_store verification failed");
		$finish;
	end

	initial begin
		in_valid = 1'b0;
		op = OP_INSERT;
		value = '0;
		cfg_valid = 1'b0;
		cfg_top_count = '0;
		arst_n = 1'b0;
		burst_left = 0;
		hold_request = 1'b0;
		refill_pool();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part with the reset value of K, which is one. A remove from
		// the empty store misses, then the extremes go in, equal values among
		// them, and removes peel the largest off one at a time.
		issue(OP_REMOVE, 32'd7);
		issue(OP_INSERT, 32'd0);
		issue(OP_INSERT, 32'hFFFF_FFFF);
		issue(OP_INSERT, 32'hFFFF_FFFF);
		issue(OP_INSERT, 32'h8000_0000);
		issue(OP_INSERT, 32'd1);
		issue(OP_INSERT, 32'd0);
		issue(OP_REMOVE, 32'd12345);
		issue(OP_REMOVE, 32'hFFFF_FFFF);
		issue(OP_REMOVE, 32'hFFFF_FFFF);
		issue(OP_INSERT, 32'h7FFF_FFFF);
		issue(OP_REMOVE, 32'd0);
		issue(OP_INSERT, 32'hAAAA_AAAA);
		issue(OP_INSERT, 32'h5555_5555);

		// A new K while values are held must be ignored: the sum below still
		// covers only the single largest value.
		quiesce();
		write_top_count(11'd500);
		issue(OP_INSERT, 32'd2);
		issue(OP_REMOVE, 32'hAAAA_AAAA);
		drain_store();

		// K written as zero reads back as one.
		quiesce();
		write_top_count(11'd0);
		refill_pool();
		random_phase(40);
		drain_store();

		// Small K; the receiver holds off for a long stretch at the start of
		// this phase while the sender keeps offering items.
		quiesce();
		write_top_count(11'd3);
		refill_pool();
		hold_request = 1'b1;
		random_phase(40);
		drain_store();

		// Just above the top of the range: clamps to 1024, so every held
		// value is summed.
		quiesce();
		write_top_count(11'd1025);
		refill_pool();
		random_phase(30);
		drain_store();

		// K somewhere near the store's typical size, so the boundary moves
		// back and forth across it.
		quiesce();
		write_top_count(11'($urandom_range(4, 40)));
		refill_pool();
		random_phase(60);
		drain_store();

		// All ones clamps to 1024. Fill the store to capacity, mostly with the
		// largest value so the sum climbs toward its top bits, then push on a
		// full store and keep it near full with mixed traffic.
		quiesce();
		write_top_count({TOP_W{1'b1}});
		refill_pool();
		repeat (STORE_DEPTH) begin
			issue(OP_INSERT, ($urandom_range(0, 3) != 0) ? {VAL_W{1'b1}} : pick_value());
		end
		repeat (4) issue(OP_INSERT, pick_value());
		random_phase(40);

		quiesce();
		if (fail_count == 0 && pending == 0) begin
			$display("top_k_sum_store verification clean");
		end else begin
			$display("top_k_sum_store verification failed");
		end
		$finish;
	end

endmodule
